/* design/fpa_pkg.sv */
// shared constants and stage structs for the fp32 adder pipeline
`default_nettype none
package fpa_pkg;

   localparam int unsigned WORD_WIDTH = 32;
   localparam int unsigned SUM_WIDTH  = 27;   // signed sum range, |sum| < 2^26
   localparam int unsigned MAG_WIDTH  = 26;
   localparam int unsigned EXP_WIDTH  = 9;

   localparam logic [7:0]  EXP_ALL1   = 8'hFF;
   localparam logic [25:0] OVF_LIMIT  = 26'h2000000;
   localparam logic [25:0] NORM_LIMIT = 26'h1000000;

   // stage 1 -> stage 2: aligned operands
   typedef struct packed {
      logic                  special;
      logic [31:0]           special_word;
      logic signed [26:0]    big_sig;
      logic signed [26:0]    small_sig;
      logic [7:0]            exp_res;
   } align_type;

   // stage 2 -> stage 3: signed sum split into sign and magnitude
   typedef struct packed {
      logic                  special;
      logic [31:0]           special_word;
      logic                  sign;
      logic [25:0]           mag;
      logic [8:0]            exp_res;
   } sum_type;

   // leading zero count over bits 24:0 of the 26-bit input, returns position distance to bit 24
   function automatic logic [4:0] lead_zero24(input logic [25:0] v);
      logic [4:0] n;
      n = 5'd24;
      for (int i = 0; i <= 24; i++) begin
         if (v[i]) n = 5'(24 - i);
      end
      return n;
   endfunction

endpackage
`default_nettype wire

/* design/fpa_norm.sv */
// normalize, round and pack stage logic (combinational)
`default_nettype none
module fpa_norm (
   input  wire fpa_pkg::sum_type s,
   output logic [31:0]           word
);
   logic [25:0] mag1, mag2, mag3;
   logic [8:0]  e1, e2, e3;
   logic [4:0]  lz;
   logic [8:0]  sh;
   logic [31:0] res;

   always_comb begin
      // overflow by one bit
      mag1 = s.mag;
      e1   = s.exp_res;
      if (s.mag >= fpa_pkg::OVF_LIMIT) begin
         mag1 = s.mag >> 1;
         e1   = s.exp_res + 9'd1;
      end
      // shift up until normal or exponent reaches zero
      lz = fpa_pkg::lead_zero24(mag1);
      sh = 9'd0;
      if (mag1 >= fpa_pkg::NORM_LIMIT) begin
         mag2 = mag1;
         e2   = e1;
      end else if (mag1 == 26'd0) begin
         // exact zero sum drains the exponent to zero
         mag2 = mag1;
         e2   = 9'd0;
      end else if ({4'd0, lz} < e1) begin
         mag2 = mag1 << lz;
         e2   = e1 - {4'd0, lz};
      end else begin
         sh   = (e1 == 9'd0) ? 9'd0 : e1 - 9'd1;
         mag2 = mag1 << sh[4:0];
         e2   = 9'd0;
      end
      // round half up on the guard bit
      mag3 = (mag2 + {25'd0, mag2[0]}) >> 1;
      e3   = e2;
      if (mag3 >= fpa_pkg::NORM_LIMIT) begin
         if (e2 != 9'd0) mag3 = mag3 >> 1;
         e3 = e2 + 9'd1;
      end
      res = {s.sign, 31'd0};
      if (e3 >= 9'd255) begin
         res = res + 32'h7F800000;
      end else if (e3 != 9'd0) begin
         res = res + {1'b0, e3[7:0], 23'd0} + {6'd0, mag3} - 32'h00800000;
      end else begin
         res = res + {6'd0, mag3};
      end
      word = s.special ? s.special_word : res;
   end
endmodule
`default_nettype wire

/* design/fp32_adder_core.sv */
// top level of the three-stage fp32 adder pipeline
// fp32_adder_core: adds two binary32 words with half-up guard rounding.
// request channel req_valid/req_ready carries req_a_word and req_b_word,
// response channel rsp_valid/rsp_ready carries rsp_sum_word.
// three register stages: align, add, normalize/round/pack. an accepted
// request passes through the align and add registers into the output
// register, which drives rsp_valid; one request per cycle is taken while
// the output is drained. the pipeline stalls as a whole when
// the last stage holds a response that rsp_ready does not take, except
// that empty stages still fill (bubbles collapse). reset clears all valid
// bits; payload registers are not reset. a NaN operand passes through,
// infinity plus finite returns the infinity, opposite infinities return
// the second word plus one. the normalize stage is set by a 25-bit
// leading zero count and shifter ahead of the output register.
`default_nettype none
module fp32_adder_core (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire  [31:0] req_a_word,
   input  wire  [31:0] req_b_word,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [31:0] rsp_sum_word
);
   logic v1_ff, v2_ff, v3_ff;
   logic en1, en2, en3;
   fpa_pkg::align_type a1_in, a1_ff;
   fpa_pkg::sum_type   s2_in, s2_ff;
   logic [31:0]        w3_in, w3_ff;

   // stall control
   assign en3 = !v3_ff || rsp_ready;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_ready = en1;

   // stage 1: unpack, specials, align
   logic [7:0] ea, eb, eam, ebm, d;
   logic signed [26:0] ma, mb, big, sml;
   logic na, nb;
   always_comb begin
      ea = req_a_word[30:23];
      eb = req_b_word[30:23];
      ma = 27'({1'b0, ea != 8'd0, req_a_word[22:0], 1'b0});
      mb = 27'({1'b0, eb != 8'd0, req_b_word[22:0], 1'b0});
      if (req_a_word[31]) ma = -ma;
      if (req_b_word[31]) mb = -mb;
      eam = (ea == 8'd0) ? 8'd1 : ea;
      ebm = (eb == 8'd0) ? 8'd1 : eb;
      if (eam > ebm) begin
         big = ma; sml = mb; d = eam - ebm; a1_in.exp_res = eam;
      end else begin
         big = mb; sml = ma; d = ebm - eam; a1_in.exp_res = ebm;
      end
      a1_in.big_sig   = big;
      a1_in.small_sig = (d >= 8'd32) ? 27'sd0 : (sml >>> d[4:0]);
      na = (ea == fpa_pkg::EXP_ALL1);
      nb = (eb == fpa_pkg::EXP_ALL1);
      a1_in.special = na || nb;
      if (na && req_a_word[22:0] != 23'd0)      a1_in.special_word = req_a_word;
      else if (nb && req_b_word[22:0] != 23'd0) a1_in.special_word = req_b_word;
      else if (!na)                             a1_in.special_word = req_b_word;
      else if (!nb)                             a1_in.special_word = req_a_word;
      else if (req_a_word == req_b_word)        a1_in.special_word = req_a_word;
      else                                      a1_in.special_word = req_b_word + 32'd1;
   end

   // stage 2: add and take magnitude
   logic signed [26:0] sum;
   always_comb begin
      sum = a1_ff.big_sig + a1_ff.small_sig;
      s2_in.special      = a1_ff.special;
      s2_in.special_word = a1_ff.special_word;
      s2_in.sign         = sum[26];
      s2_in.mag          = sum[26] ? 26'(-sum) : sum[25:0];
      s2_in.exp_res      = {1'b0, a1_ff.exp_res};
   end

   // stage 3: normalize, round, pack
   fpa_norm u_norm (.s(s2_ff), .word(w3_in));

   // pipeline registers
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
      end
      if (en1) a1_ff <= a1_in;
      if (en2) s2_ff <= s2_in;
      if (en3) w3_ff <= w3_in;
   end

   assign rsp_valid    = v3_ff;
   assign rsp_sum_word = w3_ff;
endmodule
`default_nettype wire

/* verif/fp32_adder_core_tb.sv */
// self-checking testbench for the fp32 adder pipeline
`default_nettype none
module fp32_adder_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned RANDOM_REQUESTS = 1300;
   localparam int unsigned CYCLE_LIMIT     = 400000;
   localparam int unsigned HOLD_CYCLES     = 200;
   localparam logic [31:0] EXP_FIELD  = 32'h7F800000;
   localparam logic [31:0] MANT_FIELD = 32'h007FFFFF;
   localparam logic [31:0] SIGN_BIT   = 32'h80000000;
   localparam logic [31:0] HIDDEN     = 32'h00800000;
   localparam logic [63:0] CARRY_MAG  = 64'h02000000;
   localparam logic [63:0] UNIT_MAG   = 64'h01000000;

   // sum predictor: signed significands, truncating alignment, guard rounding
   function automatic logic [31:0] fp32_sum(input logic [31:0] a, input logic [31:0] b);
      logic [7:0] ea, eb;
      logic signed [63:0] ma, mb, sum, shifted;
      logic [63:0] mag;
      int eres, sh;
      logic [31:0] res;
      ea = a[30:23];
      eb = b[30:23];
      if (ea == 8'hFF || eb == 8'hFF) begin
         if (ea == 8'hFF && (a & MANT_FIELD) != 0) return a;
         if (eb == 8'hFF && (b & MANT_FIELD) != 0) return b;
         if (ea != 8'hFF) return b;
         if (eb != 8'hFF) return a;
         if (a == b) return a;
         return b + 32'd1;
      end
      ma = 64'((a & MANT_FIELD) + (ea != 0 ? HIDDEN : 32'd0)) <<< 1;
      mb = 64'((b & MANT_FIELD) + (eb != 0 ? HIDDEN : 32'd0)) <<< 1;
      if (a[31]) ma = -ma;
      if (b[31]) mb = -mb;
      if (ea == 0) ea = 8'd1;
      if (eb == 0) eb = 8'd1;
      if (ea > eb) begin
         eres = ea;
         sh = ea - eb;
         shifted = (sh >= 32) ? 64'sd0 : (mb >>> sh);
         sum = ma + shifted;
      end else begin
         eres = eb;
         sh = eb - ea;
         shifted = (sh >= 32) ? 64'sd0 : (ma >>> sh);
         sum = mb + shifted;
      end
      res = (sum < 0) ? SIGN_BIT : 32'd0;
      mag = (sum < 0) ? 64'(-sum) : 64'(sum);
      if (mag >= CARRY_MAG) begin
         if (eres > 0) mag = mag >> 1;
         eres++;
      end
      while (mag < UNIT_MAG && eres > 0) begin
         eres--;
         if (eres > 0) mag = mag << 1;
      end
      mag = (mag + (mag & 64'd1)) >> 1;
      if (mag >= UNIT_MAG) begin
         if (eres > 0) mag = mag >> 1;
         eres++;
      end
      if (eres >= 255) return res + EXP_FIELD;
      res = res + (32'(eres) << 23);
      if (eres > 0) return res + 32'(mag) - HIDDEN;
      return res + 32'(mag);
   endfunction

   // queue of expected sums, checked in order
   class sum_scoreboard;
      logic [31:0] pending_sums[$];
      int mismatches = 0;

      function void note_request(logic [31:0] a, logic [31:0] b);
         pending_sums.push_back(fp32_sum(a, b));
      endfunction

      function void check_sum(logic [31:0] got);
         logic [31:0] want;
         if (pending_sums.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %h", got);
            return;
         end
         want = pending_sums.pop_front();
         if (want !== got) begin
            mismatches++;
            if (mismatches <= 10) $display("sum mismatch: expected %h got %h", want, got);
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [31:0] req_a_word;
   logic [31:0] req_b_word;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_sum_word;

   sum_scoreboard board;
   int  cycles;
   bit  long_hold;

   fp32_adder_core uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_a_word(req_a_word), .req_b_word(req_b_word),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_sum_word(rsp_sum_word)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // offer one request and hold it until taken
   task automatic send_request(input logic [31:0] a, input logic [31:0] b);
      @(negedge clock);
      req_valid  <= 1'b1;
      req_a_word <= a;
      req_b_word <= b;
      do @(posedge clock); while (!(req_ready === 1'b1));
      board.note_request(a, b);
   endtask

   task automatic idle_sender(input int n);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   // random operand weighted toward specials and close exponents
   function automatic logic [31:0] pick_word(input logic [31:0] other);
      logic [31:0] w;
      logic [7:0]  e;
      w = $urandom;
      case ($urandom_range(0, 9))
         0: w[30:23] = 8'hFF;
         1: w[30:23] = 8'h00;
         2: w[30:23] = 8'hFE;
         3: begin
            e = other[30:23] + 8'($urandom_range(0, 4)) - 8'd2;
            w[30:23] = e;
         end
         4: w = other ^ SIGN_BIT ^ 32'($urandom_range(0, 3));
         default: ;
      endcase
      return w;
   endfunction

   // receiver stall pattern plus one long hold-off timed here
   initial begin
      int phase;
      rsp_ready = 1'b0;
      phase = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         phase++;
         if (long_hold) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            long_hold = 1'b0;
         end
         else if ((phase / 64) % 3 == 0) rsp_ready <= 1'b1;
         else rsp_ready <= ($urandom_range(0, 3) != 0);
      end
   end

   // response checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_sum(rsp_sum_word);
   end

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // stimulus
   initial begin
      logic [31:0] directed[$];
      logic [31:0] a, b;
      int i, burst;
      bit hold_done, drain_done;
      board = new();
      long_hold = 1'b0;
      hold_done = 1'b0;
      drain_done = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_a_word = '0;
      req_b_word = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // extremes and special cases, pairs of a and b
      directed = '{32'h00000000, 32'h00000000, 32'h80000000, 32'h80000000,
                   32'h7FC00001, 32'h3F800000, 32'h3F800000, 32'hFF800123,
                   32'h7F800000, 32'h3F800000, 32'h40000000, 32'hFF800000,
                   32'h7F800000, 32'h7F800000, 32'h7F800000, 32'hFF800000,
                   32'h7F7FFFFF, 32'h7F7FFFFF, 32'hFF7FFFFF, 32'hFF7FFFFF,
                   32'h00000001, 32'h007FFFFF, 32'h807FFFFF, 32'h00000003,
                   32'h3F800000, 32'hBF800000, 32'h3F800000, 32'h33800000,
                   32'h4B000000, 32'h00000001, 32'hFFFFFFFF, 32'h00000000,
                   32'h3FFFFFFF, 32'h3FFFFFFF, 32'h00800000, 32'h80800001};
      for (i = 0; i < directed.size(); i += 2) send_request(directed[i], directed[i + 1]);

      // random bursts; one long receiver hold-off, one drain pause
      i = 0;
      while (i < RANDOM_REQUESTS) begin
         if (!hold_done && i >= 300) begin
            long_hold = 1'b1;
            hold_done = 1'b1;
         end
         if (!drain_done && i >= 700) begin
            drain_done = 1'b1;
            idle_sender(1);
            while (board.pending_sums.size() != 0) @(negedge clock);
         end
         burst = $urandom_range(1, 40);
         repeat (burst) begin
            a = ($urandom_range(0, 7) == 0) ? $urandom : pick_word($urandom);
            b = pick_word(a);
            if ($urandom_range(0, 1)) send_request(a, b);
            else send_request(b, a);
            i++;
         end
         if ($urandom_range(0, 2) != 0) idle_sender($urandom_range(0, 6));
      end
      idle_sender(0);

      while (board.pending_sums.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (board.mismatches == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end
endmodule
`default_nettype wire
